>>> hdl/dti_pkg.sv
// shared constants and types for the daytime tint interpolator
package dti_pkg;

    localparam int MAX_MARKS_DEF = 8;
    localparam int TIME_BITS_DEF = 20;
    localparam int DUR_W         = 20;
    localparam int SPD_W         = 16;
    localparam int ELAPSED_W     = 16;
    localparam int CH_W          = 8;
    localparam int IN_DATA_W     = 96;
    localparam int OUT_DATA_W    = 64;

    // request kinds
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_SET  = 2'd1;
    localparam logic [1:0] REQ_MARK = 2'd2;

    // configuration register indexes
    localparam logic [0:0] CFG_DAY_DURATION = 1'd0;
    localparam logic [0:0] CFG_SPEEDUP      = 1'd1;

    // luminance weights, Q0.16
    localparam logic [15:0] LUM_R = 16'd13933;
    localparam logic [15:0] LUM_G = 16'd46871;
    localparam logic [15:0] LUM_B = 16'd4732;

    // command to the shared divider
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
        logic [31:0] remainder;
    } t_div_rsp;

endpackage

>>> hdl/dti_divider.sv
// shared restoring divider, one quotient bit per cycle
module dti_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dti_pkg::t_div_req i_req,
    output dti_pkg::t_div_rsp o_rsp
);

    logic [63:0] r_quo, n_quo;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_dsr, n_dsr;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] w_trial;

    assign w_trial = {r_rem, r_quo[63]} - {1'b0, r_dsr};

    // one shift-subtract step per cycle
    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_dsr  = i_req.divisor;
            n_cnt  = 7'd64;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[32]) begin
                n_rem = w_trial[31:0];
                n_quo = {r_quo[62:0], 1'b1};
            end else begin
                n_rem = {r_rem[30:0], r_quo[63]};
                n_quo = {r_quo[62:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

    property p_done_single;
        @(posedge i_clk) disable iff (!i_rst_n) r_done |=> !r_done;
    endproperty
    a_done_single: assert property (p_done_single) else $error("divider done held");

    property p_done_after_busy;
        @(posedge i_clk) disable iff (!i_rst_n) r_done |-> !r_busy;
    endproperty
    a_done_after_busy: assert property (p_done_after_busy) else $error("done while busy");

    property p_start_busy;
        @(posedge i_clk) disable iff (!i_rst_n) i_req.start |=> r_busy;
    endproperty
    a_start_busy: assert property (p_start_busy) else $error("divider did not start");

endmodule

>>> hdl/daytime_tint_interpolator.sv
// top level: time counter, keyframe table, sequencer around a shared divider
// one item at a time; the input is not ready again until the current item is done
// the shared 64-bit divider (one modulo, up to four channel divisions) sets the tick length
// reset: i_rst_n synchronous active low, time 0, no marks, speedup 1.0
// the keyframe table is not cleared; entries are undefined until written
module daytime_tint_interpolator #(
    parameter int MAX_MARKS = dti_pkg::MAX_MARKS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // cfg channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic                            i_cfg_index,
    input  logic [31:0]                     i_cfg_data,
    // tdata: elapsed, new_time, mark_index, mark_start, red, green, blue, alpha, is_final,
    // zero fill
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [dti_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: req_type
    input  logic [1:0]                      s_axis_tuser,
    // tdata: red, green, blue, alpha, darkness, time_now, zero fill
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [dti_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    localparam int TIME_BITS = dti_pkg::TIME_BITS_DEF;
    localparam int IW = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1;
    localparam int CW = $clog2(MAX_MARKS + 1);

    localparam logic [3:0] S_IDLE = 4'd0, S_MUL = 4'd1, S_MOD = 4'd3,
                           S_DIV2 = 4'd4, S_SCAN = 4'd5, S_SEG = 4'd6, S_MIX = 4'd7,
                           S_MIXW = 4'd8, S_LUM = 4'd9, S_OUT = 4'd10, S_SET = 4'd11;

    // input fields
    logic [15:0] w_elapsed;
    logic [19:0] w_new_time, w_mark_start;
    logic [2:0]  w_mark_index;
    logic [31:0] w_color;
    logic        w_final;
    assign w_elapsed    = s_axis_tdata[15:0];
    assign w_new_time   = s_axis_tdata[35:16];
    assign w_mark_index = s_axis_tdata[38:36];
    assign w_mark_start = s_axis_tdata[58:39];
    assign w_color      = s_axis_tdata[90:59];
    assign w_final      = s_axis_tdata[91];

    logic [19:0] r_day;
    logic [15:0] r_spd;
    logic [3:0]  r_st;
    logic [TIME_BITS:0] r_time;
    logic [CW-1:0] r_count;
    logic [TIME_BITS-1:0] r_starts [MAX_MARKS];
    logic [31:0]          r_colors [MAX_MARKS];

    logic [1:0]  r_req;
    logic [19:0] r_nt, r_ms;
    logic [2:0]  r_mi;
    logic [31:0] r_mc;
    logic        r_mf;

    logic signed [33:0] r_prod;
    logic signed [34:0] r_sum;
    logic [IW-1:0] r_i, r_cur;
    logic [31:0] r_span, r_diff;
    logic [2:0]  r_ch;
    logic [7:0]  r_rgba [4];
    logic [7:0]  r_night;
    logic        r_oval;
    logic [63:0] r_odata;

    dti_pkg::t_div_req w_dreq;
    dti_pkg::t_div_rsp w_drsp;

    dti_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    assign o_cfg_ready   = (r_st == S_IDLE);
    assign s_axis_tready = (r_st == S_IDLE);
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_odata;

    // channel mix terms
    logic [7:0]  w_ca, w_cb;
    logic [IW-1:0] w_nxt;
    logic [31:0] w_nstart;
    logic        w_last;
    assign w_last   = ({{(32-IW){1'b0}}, r_cur} + 32'd1 >= {{(32-CW){1'b0}}, r_count});
    assign w_nxt    = w_last ? '0 : r_cur + IW'(1);
    assign w_nstart = w_last ? {12'd0, r_day} : {{(32-TIME_BITS){1'b0}}, r_starts[w_nxt]};
    assign w_ca     = r_colors[r_cur][8*r_ch[1:0] +: 8];
    assign w_cb     = r_colors[w_nxt][8*r_ch[1:0] +: 8];

    logic [63:0] w_mixnum;
    assign w_mixnum = 64'(w_ca) * 64'(r_span - r_diff) + 64'(w_cb) * 64'(r_diff)
                    + 64'(r_span >> 1);

    logic [33:0] w_abs;
    assign w_abs = r_prod[33] ? 34'(-r_prod) : 34'(r_prod);

    logic signed [34:0] w_now;
    logic [31:0] w_cs;
    logic signed [34:0] w_sp, w_df;
    assign w_cs = {{(32-TIME_BITS){1'b0}}, r_starts[r_cur]};
    assign w_sp = 35'(w_nstart) - 35'(w_cs);
    assign w_df = 35'(r_time) - 35'(w_cs);

    logic [25:0] w_lum_acc;
    assign w_lum_acc = 26'(r_rgba[0]) * 26'(dti_pkg::LUM_R)
                     + 26'(r_rgba[1]) * 26'(dti_pkg::LUM_G)
                     + 26'(r_rgba[2]) * 26'(dti_pkg::LUM_B);
    logic [25:0] w_lum;
    assign w_lum = w_lum_acc + 26'(32768);

    always_comb begin
        w_dreq.start    = 1'b0;
        w_dreq.dividend = '0;
        w_dreq.divisor  = '0;
        if (r_st == S_MOD) begin
            w_dreq.start    = 1'b1;
            w_dreq.dividend = r_sum[34] ? 64'(-r_sum) : 64'(r_sum);
            w_dreq.divisor  = {12'd0, r_day};
        end else if (r_st == S_MIX) begin
            w_dreq.start    = 1'b1;
            w_dreq.dividend = w_mixnum;
            w_dreq.divisor  = r_span;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_day   <= '0;
            r_spd   <= 16'd256;
            r_time  <= '0;
            r_count <= '0;
            r_oval  <= 1'b0;
        end else begin
            if (r_oval && m_axis_tready) r_oval <= 1'b0;
            // configuration writes
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == dti_pkg::CFG_DAY_DURATION) r_day <= i_cfg_data[19:0];
                else r_spd <= i_cfg_data[15:0];
            end
            case (r_st)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_req <= s_axis_tuser; r_nt <= w_new_time;
                        r_mi <= w_mark_index; r_ms <= w_mark_start; r_mc <= w_color;
                        r_mf <= w_final;
                        r_st <= (s_axis_tuser == dti_pkg::REQ_TICK) ? S_MUL : S_SET;
                        r_prod <= 34'(signed'(s_axis_tdata[15:0] == 16'd0 ? 17'sd0 :
                                  34'(signed'(r_spd)) * 34'(signed'({1'b0, w_elapsed}))));
                    end
                end
                S_SET: begin
                    if (r_req == dti_pkg::REQ_SET) begin
                        r_time <= (TIME_BITS+1)'(r_nt[TIME_BITS-1:0]);
                    end else if (r_req == dti_pkg::REQ_MARK) begin
                        if (32'(r_mi) < MAX_MARKS) begin
                            r_starts[IW'(r_mi)] <= r_ms[TIME_BITS-1:0];
                            r_colors[IW'(r_mi)] <= r_mc;
                            if (r_mf) r_count <= CW'({1'b0, r_mi} + 4'd1);
                        end
                    end
                    r_st <= S_IDLE;
                end
                // advance by the product over 256, truncated toward zero
                S_MUL: begin
                    r_sum <= 35'(r_time) + (r_prod[33] ? -35'(w_abs >> 8) : 35'(w_abs >> 8));
                    r_st  <= S_MOD;
                end
                S_MOD: begin
                    if (r_day == '0) begin
                        r_time <= '0;
                        r_st   <= S_DIV2;
                    end else r_st <= S_DIV2;
                end
                S_DIV2: begin
                    if (r_day == '0 || w_drsp.done) begin
                        if (r_day != '0) begin
                            if (r_sum[34] && w_drsp.remainder != 0)
                                r_time <= (TIME_BITS+1)'({12'd0, r_day} - w_drsp.remainder);
                            else
                                r_time <= (TIME_BITS+1)'(w_drsp.remainder);
                        end
                        r_i <= '0; r_cur <= '0;
                        r_st <= (r_count == '0) ? S_IDLE : S_SCAN;
                    end
                end
                // one mark compared per cycle
                S_SCAN: begin
                    if (35'(r_starts[r_i]) > 35'(r_time)) r_st <= S_SEG;
                    else begin
                        r_cur <= r_i;
                        if (32'(r_i) + 1 >= 32'(r_count)) r_st <= S_SEG;
                        else r_i <= r_i + IW'(1);
                    end
                end
                S_SEG: begin
                    if (w_sp <= 0 || w_df <= 0) begin r_span <= '0; r_diff <= '0; end
                    else begin
                        r_span <= w_sp[31:0];
                        r_diff <= (w_df > w_sp) ? w_sp[31:0] : w_df[31:0];
                    end
                    r_ch <= '0;
                    r_st <= S_MIX;
                end
                S_MIX: begin
                    if (r_span == '0) begin
                        r_rgba[r_ch[1:0]] <= w_ca;
                        r_ch <= r_ch + 3'd1;
                        if (r_ch == 3'd3) r_st <= S_LUM;
                    end else r_st <= S_MIXW;
                end
                S_MIXW: begin
                    if (w_drsp.done) begin
                        r_rgba[r_ch[1:0]] <= w_drsp.quotient[7:0];
                        r_ch <= r_ch + 3'd1;
                        r_st <= (r_ch == 3'd3) ? S_LUM : S_MIX;
                    end
                end
                S_LUM: begin
                    r_night <= (w_lum[25:16] > 10'd255) ? 8'd0 : 8'd255 - w_lum[23:16];
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    if (!r_oval) begin
                        r_oval  <= 1'b1;
                        r_odata <= {4'd0, r_time[19:0], r_night,
                                    r_rgba[3], r_rgba[2], r_rgba[1], r_rgba[0]};
                        r_st    <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    property p_busy_not_ready;
        @(posedge i_clk) disable iff (!i_rst_n) (r_st == S_SCAN) |-> !s_axis_tready;
    endproperty
    a_busy_not_ready: assert property (p_busy_not_ready) else $error("ready while busy");

    property p_out_from_lum;
        @(posedge i_clk) disable iff (!i_rst_n) $rose(r_oval) |-> $past(r_st) == S_OUT;
    endproperty
    a_out_from_lum: assert property (p_out_from_lum) else $error("result from wrong state");

    property p_count_range;
        @(posedge i_clk) disable iff (!i_rst_n) 32'(r_count) <= MAX_MARKS;
    endproperty
    a_count_range: assert property (p_count_range) else $error("mark count too big");

endmodule

>>> verif/daytime_tint_interpolator_tb.sv
// testbench for the daytime tint interpolator: keyframe table, ticks and tint checks
module daytime_tint_interpolator_tb;

    localparam int  N_MARKS     = dti_pkg::MAX_MARKS_DEF;
    localparam int  SETTLE      = 800;
    localparam longint LIMIT    = 3000000;
    localparam logic [1:0] REQ_BOGUS = 2'd3;

    // one input beat, unpacked
    typedef struct {
        logic [1:0]  req;
        logic [15:0] elapsed;
        logic [19:0] new_time;
        logic [2:0]  slot;
        logic [19:0] start;
        logic [7:0]  red, green, blue, alpha;
        logic        is_final;
    } t_tint_req;

    typedef struct {
        logic [7:0]  red, green, blue, alpha, night;
        logic [19:0] time_now;
    } t_tint;

    // tint predictor and expected-tint queue
    class t_tint_scoreboard;
        logic [19:0] day_len;
        logic signed [15:0] rate;
        longint      clock_now;
        logic [19:0] starts [N_MARKS];
        logic [31:0] colors [N_MARKS];
        int          used;
        t_tint       pending_tints[$];
        int          errors;

        function void clear();
            day_len   = '0;
            rate      = 16'sd256;
            clock_now = 0;
            used      = 0;
            errors    = 0;
            foreach (starts[i]) begin
                starts[i] = '0;
                colors[i] = '0;
            end
        endfunction

        function void set_reg(logic idx, logic [31:0] val);
            if (idx == dti_pkg::CFG_DAY_DURATION) day_len = val[19:0];
            else rate = val[15:0];
        endfunction

        function longint blend(logic [7:0] a, logic [7:0] b, longint d, longint span);
            if (span == 0) return longint'(a);
            return (longint'(a) * (span - d) + longint'(b) * d + span / 2) / span;
        endfunction

        // advance the model by one accepted beat
        function void note_item(t_tint_req it);
            longint prod, t, cs, ns, span, d, r, g, b, a, lum;
            int cur, nxt;
            t_tint e;
            if (it.req == dti_pkg::REQ_SET) begin
                clock_now = longint'(it.new_time);
                return;
            end
            if (it.req == dti_pkg::REQ_MARK) begin
                starts[it.slot] = it.start;
                colors[it.slot] = {it.alpha, it.blue, it.green, it.red};
                if (it.is_final) used = it.slot + 1;
                return;
            end
            if (it.req != dti_pkg::REQ_TICK) return;
            prod = longint'(rate) * longint'(it.elapsed);
            t = clock_now + prod / 256;
            if (day_len > 0) begin
                t = t % longint'(day_len);
                if (t < 0) t += longint'(day_len);
            end else begin
                t = 0;
            end
            clock_now = t;
            if (used == 0) return;
            cur = 0;
            for (int i = 0; i < used; i++) begin
                if (longint'(starts[i]) > t) break;
                cur = i;
            end
            cs = longint'(starts[cur]);
            if (cur + 1 < used) begin
                nxt = cur + 1;
                ns  = longint'(starts[nxt]);
            end else begin
                nxt = 0;
                ns  = longint'(day_len);
            end
            span = ns - cs;
            d    = t - cs;
            if (span <= 0 || d <= 0) begin
                span = 0;
                d    = 0;
            end else if (d > span) begin
                d = span;
            end
            r = blend(colors[cur][7:0],   colors[nxt][7:0],   d, span);
            g = blend(colors[cur][15:8],  colors[nxt][15:8],  d, span);
            b = blend(colors[cur][23:16], colors[nxt][23:16], d, span);
            a = blend(colors[cur][31:24], colors[nxt][31:24], d, span);
            lum = (13933 * r + 46871 * g + 4732 * b + 32768) >>> 16;
            if (lum > 255) lum = 255;
            e.red = r[7:0]; e.green = g[7:0]; e.blue = b[7:0]; e.alpha = a[7:0];
            e.night = 8'(255 - lum);
            e.time_now = t[19:0];
            pending_tints.push_back(e);
        endfunction

        function void check_result(logic [dti_pkg::OUT_DATA_W-1:0] data);
            t_tint e;
            if (pending_tints.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %h", data);
                return;
            end
            e = pending_tints.pop_front();
            if (data[7:0] !== e.red || data[15:8] !== e.green || data[23:16] !== e.blue ||
                data[31:24] !== e.alpha || data[39:32] !== e.night ||
                data[59:40] !== e.time_now) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp r%0d g%0d b%0d a%0d n%0d t%0d got %h",
                             e.red, e.green, e.blue, e.alpha, e.night, e.time_now, data);
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic i_cfg_valid, o_cfg_ready, i_cfg_index;
    logic [31:0] i_cfg_data;
    logic s_axis_tvalid, s_axis_tready;
    logic [dti_pkg::IN_DATA_W-1:0] s_axis_tdata;  // elapsed, new_time, slot, start, r, g, b, a, final
    logic [1:0] s_axis_tuser;                     // req_type
    logic m_axis_tvalid, m_axis_tready;
    logic [dti_pkg::OUT_DATA_W-1:0] m_axis_tdata; // r, g, b, a, night, time_now

    t_tint_scoreboard sb;
    int     idle_mode;
    longint cycles = 0;
    bit     written [N_MARKS];

    daytime_tint_interpolator uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("daytime_tint_interpolator_tb: errors");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (idle_mode == 0) m_axis_tready <= ($urandom_range(99) >= 63);
        else if (idle_mode == 1) m_axis_tready <= ($urandom_range(99) >= 8);
        else m_axis_tready <= 1'b1;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    task automatic write_reg(logic idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic send(t_tint_req it);
        int gap_pct;
        gap_pct = (idle_mode == 0) ? 8 : (idle_mode == 1) ? 63 : 0;
        if ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.req;
        s_axis_tdata  <= {4'd0, it.is_final, it.alpha, it.blue, it.green, it.red,
                          it.start, it.slot, it.new_time, it.elapsed};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(it);
    endtask

    function automatic t_tint_req blank(logic [1:0] req);
        t_tint_req it;
        it.req = req; it.elapsed = '0; it.new_time = '0; it.slot = '0; it.start = '0;
        it.red = '0; it.green = '0; it.blue = '0; it.alpha = '0; it.is_final = 1'b0;
        return it;
    endfunction

    task automatic tick(logic [15:0] el);
        t_tint_req it;
        it = blank(dti_pkg::REQ_TICK);
        it.elapsed = el;
        send(it);
    endtask

    task automatic set_time(logic [19:0] t);
        t_tint_req it;
        it = blank(dti_pkg::REQ_SET);
        it.new_time = t;
        send(it);
    endtask

    task automatic put_mark(logic [2:0] slot, logic [19:0] st, logic [31:0] rgba, logic fin);
        t_tint_req it;
        it = blank(dti_pkg::REQ_MARK);
        it.slot = slot; it.start = st;
        {it.alpha, it.blue, it.green, it.red} = rgba;
        it.is_final = fin;
        written[slot] = 1'b1;
        send(it);
    endtask

    // drain outstanding tints, then let a no-result item finish
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_tints.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic directed();
        t_tint_req it;
        tick(16'd10);                                   // no marks yet
        put_mark(3'd0, 20'd100, 32'h00000000, 1'b0);
        put_mark(3'd1, 20'd400, 32'hFFFFFFFF, 1'b0);
        put_mark(3'd2, 20'd400, 32'h80402010, 1'b0);    // zero span behind slot 1
        put_mark(3'd3, 20'd700, 32'h11223344, 1'b1);
        put_mark(3'd7, 20'hFFFFF, 32'hA5A5A5A5, 1'b0);
        set_time(20'd0);
        tick(16'd0);                                    // before first mark
        tick(16'd250);
        tick(16'd1);
        tick(16'hFFFF);
        set_time(20'hFFFFF);
        tick(16'd0);
        set_time(20'd800);
        tick(16'd0);                                    // last segment wraps to first
        it = blank(REQ_BOGUS);
        it.elapsed = 16'hFFFF;
        send(it);                                       // ignored kind
        put_mark(3'd1, 20'd900, 32'h00FF00FF, 1'b0);    // unsorted starts
        set_time(20'd500);
        tick(16'd3);
        put_mark(3'd0, 20'd0, 32'hFF0000FF, 1'b1);      // single mark
        tick(16'd128);
        put_mark(3'd3, 20'd700, 32'h11223344, 1'b1);
        tick(16'd7);
    endtask

    task automatic random_items(int n, logic [19:0] dur);
        t_tint_req it;
        int k, all_below;
        for (int i = 0; i < n; i++) begin
            k  = $urandom_range(99);
            it = blank(dti_pkg::REQ_TICK);
            it.elapsed  = 16'($urandom);
            it.new_time = 20'($urandom);
            it.start    = 20'($urandom);
            {it.alpha, it.blue, it.green, it.red} = $urandom;
            if (k < 55) begin
                if ($urandom_range(3) != 0) it.elapsed = 16'($urandom_range(0, 400));
                send(it);
            end else if (k < 65) begin
                it.req = dti_pkg::REQ_SET;
                if (dur > 0 && $urandom_range(3) != 0)
                    it.new_time = 20'($urandom_range(0, dur - 1));
                send(it);
            end else if (k < 95) begin
                it.req  = dti_pkg::REQ_MARK;
                it.slot = 3'($urandom_range(0, N_MARKS - 1));
                // mostly ascending starts spread over the day
                if ($urandom_range(9) != 0)
                    it.start = 20'((longint'(dur) * it.slot) / N_MARKS +
                                   $urandom_range(0, dur / 16 + 1));
                written[it.slot] = 1'b1;
                all_below = 1;
                for (int j = 0; j <= it.slot; j++) if (!written[j]) all_below = 0;
                it.is_final = all_below && ($urandom_range(99) < 30);
                send(it);
            end else begin
                it.req = REQ_BOGUS;
                it.is_final = 1'($urandom);
                send(it);
            end
        end
    endtask

    initial begin
        logic [19:0] durs [8];
        logic [15:0] rates [8];
        sb = new();
        sb.clear();
        durs  = '{20'd1000, 20'd0, 20'hFFFFF, 20'hFFFFF, 20'd5000, 20'd3, 20'd100000, 20'd1};
        rates = '{16'd256, 16'd256, 16'h7FFF, 16'h8000, -16'sd300, 16'd0, 16'd1200, 16'd256};
        foreach (written[i]) written[i] = 1'b0;
        idle_mode     = 0;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= dti_pkg::REQ_TICK;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int p = 0; p < 8; p++) begin
            // receiver stalls first, then sender gaps, then full speed
            idle_mode = (p * 3) / 8;
            write_reg(dti_pkg::CFG_DAY_DURATION, 32'(durs[p]));
            write_reg(dti_pkg::CFG_SPEEDUP, 32'(rates[p]));
            if (p == 0) directed();
            random_items(125, durs[p]);
            settle();
        end
        if (sb.errors == 0 && sb.pending_tints.size() == 0) begin
            $display("daytime_tint_interpolator_tb: clean");
        end else begin
            $display("daytime_tint_interpolator_tb: errors");
        end
        $finish;
    end

endmodule
